/* rtl/core/lvlm_pkg.sv */
// Package with shared types, constants and the log2 mantissa table of the level meter.
`timescale 1ns / 1ps

package lvlm_pkg;

	localparam int unsigned K_W = 23;
	localparam logic [K_W-1:0] K20_Q16 = 23'd6313057;
	localparam logic [K_W-1:0] K10_Q16 = 23'd3156528;
	localparam int unsigned SUM_W = 64;
	localparam int unsigned LVL_W = 16;
	localparam logic signed [11:0] FLOOR_RESET = -12'sd576;

	typedef struct packed {
		logic load_in;
		logic do_mul;
		logic do_acc;
		logic div_start;
		logic div_step;
		logic log_load;
		logic log_sel;
		logic log_norm;
		logic log_sub;
		logic log_prod;
		logic log_fin;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic last_s1;
		logic div_last;
		logic norm_done;
		logic out_free;
	} dp_sts_t;

	// Entry i is log2(1 + i/64) in Q16, built by repeated squaring.
	function automatic logic [1023:0] build_log_tab();
		logic [63:0] x;
		logic [15:0] r;
		logic [1023:0] t;
		t = '0;
		for (int i = 0; i < 64; i++) begin
			x = 64'(64 + i) << 24;
			r = '0;
			for (int b = 0; b < 16; b++) begin
				x = (x * x) >> 30;
				r = {r[14:0], 1'b0};
				if (x >= 64'h8000_0000) begin
					r[0] = 1'b1;
					x = x >> 1;
				end
			end
			t[i*16 +: 16] = r;
		end
		return t;
	endfunction

	localparam logic [1023:0] LOG_TAB = build_log_tab();

endpackage

/* rtl/core/block_peak_rms_level_meter.sv */
// Top level of the block peak and RMS level meter in 1/16 dBFS.
// A sample request passes the magnitude and peak, square and accumulate steps in turn.
// A last sample adds a divider load, the divider steps, two log passes for peak
// and RMS (load, leading-one search, subtract, product, finish) and an output step.
// The result waits in an output register; the output step repeats until it is free.
// Reset clears all accumulators and sets the floor to -36 dB.
`timescale 1ns / 1ps

module block_peak_rms_level_meter
	import lvlm_pkg::*;
#(
	parameter int unsigned MAX_BLOCK   = 4096,
	parameter int unsigned SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [11:0]            peak_db,
	output logic signed [11:0]            rms_db,
	output logic [10:0]                   crest_db,
	output logic                          block_too_long,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [11:0]                   cfg_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	lvlm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lvlm_datapath #(
		.MAX_BLOCK   (MAX_BLOCK),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.sample         (sample),
		.last           (last),
		.cfg_valid      (cfg_valid),
		.cfg_data       (cfg_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.peak_db        (peak_db),
		.rms_db         (rms_db),
		.crest_db       (crest_db),
		.block_too_long (block_too_long)
	);

endmodule

/* rtl/core/lvlm_ctrl.sv */
// Controller state machine that sequences accumulation, division and level conversion.
`timescale 1ns / 1ps

module lvlm_ctrl
	import lvlm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL, ST_ACC, ST_DIV_LD, ST_DIV, ST_LOG_LD, ST_LOG_NORM,
		ST_LOG_SUB, ST_LOG_PROD, ST_LOG_FIN, ST_OUT
	} state_t;

	state_t state_q;
	logic   sel_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		cmd.log_sel = sel_q;
		case (state_q)
			ST_IDLE:     cmd.load_in = in_valid;
			ST_MUL:      cmd.do_mul = 1'b1;
			ST_ACC:      cmd.do_acc = 1'b1;
			ST_DIV_LD:   cmd.div_start = 1'b1;
			ST_DIV:      cmd.div_step = 1'b1;
			ST_LOG_LD:   cmd.log_load = 1'b1;
			ST_LOG_NORM: cmd.log_norm = 1'b1;
			ST_LOG_SUB:  cmd.log_sub = 1'b1;
			ST_LOG_PROD: cmd.log_prod = 1'b1;
			ST_LOG_FIN:  cmd.log_fin = 1'b1;
			ST_OUT:      cmd.out_load = sts.out_free;
			default:     cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_MUL;
				end
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: state_q <= sts.last_s1 ? ST_DIV_LD : ST_IDLE;
				ST_DIV_LD: state_q <= ST_DIV;
				ST_DIV: begin
					if (sts.div_last) begin
						state_q <= ST_LOG_LD;
						sel_q   <= 1'b0;
					end
				end
				ST_LOG_LD: state_q <= ST_LOG_NORM;
				ST_LOG_NORM: begin
					if (sts.norm_done) state_q <= ST_LOG_SUB;
				end
				ST_LOG_SUB:  state_q <= ST_LOG_PROD;
				ST_LOG_PROD: state_q <= ST_LOG_FIN;
				ST_LOG_FIN: begin
					if (sel_q) begin
						state_q <= ST_OUT;
					end else begin
						sel_q   <= 1'b1;
						state_q <= ST_LOG_LD;
					end
				end
				ST_OUT: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* rtl/core/lvlm_datapath.sv */
// Datapath with accumulators, restoring divider, shared log unit and output register.
`timescale 1ns / 1ps

module lvlm_datapath
	import lvlm_pkg::*;
#(
	parameter int unsigned MAX_BLOCK   = 4096,
	parameter int unsigned SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dp_cmd_t                       cmd,
	output dp_sts_t                       sts,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          last,
	input  logic                          cfg_valid,
	input  logic [11:0]                   cfg_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [11:0]            peak_db,
	output logic signed [11:0]            rms_db,
	output logic [10:0]                   crest_db,
	output logic                          block_too_long
);

	localparam int unsigned PK_W = SAMPLE_BITS - 1;
	localparam int unsigned MAG_W = SAMPLE_BITS;
	localparam int unsigned SQ_W = 2 * SAMPLE_BITS;
	localparam int unsigned TW = $clog2(MAX_BLOCK + 1);
	localparam logic [5:0] REF_PK = 6'(SAMPLE_BITS - 1);
	localparam logic [5:0] REF_MS = 6'(2 * (SAMPLE_BITS - 1));

	logic signed [11:0] floor_q;
	logic [PK_W-1:0]    peak_q;
	logic [SUM_W-1:0]   sum_q;
	logic [TW-1:0]      tally_q;
	logic               ovf_q;
	logic [MAG_W-1:0]   mag_s1;
	logic               last_s1;
	logic [SQ_W-1:0]    sq_s2;

	logic [PK_W-1:0]    pk_hold_q;
	logic               res_ovf_q;
	logic               tzero_q;
	logic [SUM_W-1:0]   dvd_q;
	logic [TW-1:0]      dvs_q;
	logic [TW-1:0]      rem_q;
	logic [5:0]         div_cnt_q;

	logic [63:0]        lx_q;
	logic [5:0]         lp_q;
	logic               lzero_q;
	logic               ge_q;
	logic [21:0]        diff_q;
	logic [44:0]        lprod_q;
	logic signed [LVL_W-1:0] pres_q;
	logic signed [LVL_W-1:0] rres_q;
	logic               out_valid_q;

	logic [MAG_W-1:0]   mag;
	logic [PK_W-1:0]    pk_in;
	logic [SUM_W:0]     sum_add;
	logic [TW:0]        rem2;
	logic               qbit;
	logic [21:0]        l22;
	logic [21:0]        ref22;
	logic [15:0]        tab_val;
	logic [45:0]        nsum;
	logic [13:0]        nval;
	logic signed [LVL_W-1:0] lv;
	logic signed [LVL_W-1:0] floor16;
	logic signed [LVL_W-1:0] lvl;
	logic signed [LVL_W:0]   crest;

	assign mag = sample[SAMPLE_BITS-1] ? MAG_W'(~sample + 1'b1) : MAG_W'(sample);
	assign pk_in = mag[MAG_W-1] ? {PK_W{1'b1}} : mag[PK_W-1:0];
	assign sum_add = {1'b0, sum_q} + (SUM_W + 1)'(sq_s2);
	assign rem2 = {rem_q, dvd_q[SUM_W-1]};
	assign qbit = (rem2 >= {1'b0, dvs_q});
	assign tab_val = LOG_TAB[lx_q[62:57]*16 +: 16];
	assign l22 = {lp_q, 16'd0} + {6'd0, tab_val};
	assign ref22 = {(lzero_q ? 6'd0 : (cmd.log_sel ? REF_MS : REF_PK)), 16'd0};
	assign nsum = {1'b0, lprod_q} + 46'h0000_8000_0000;
	assign nval = nsum[45:32];
	assign lv = ge_q ? '0 : -$signed({2'b00, nval});
	assign floor16 = LVL_W'(floor_q);
	assign lvl = (lzero_q || lv < floor16) ? floor16 : lv;
	assign crest = LVL_W'(pres_q) - LVL_W'(rres_q);

	assign sts.last_s1 = last_s1;
	assign sts.div_last = &div_cnt_q;
	assign sts.norm_done = lx_q[63] || (lp_q == 6'd0);
	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q     <= FLOOR_RESET;
			peak_q      <= '0;
			sum_q       <= '0;
			tally_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) floor_q <= cfg_data;
			if (cmd.load_in && pk_in > peak_q) peak_q <= pk_in;
			if (cmd.do_acc) begin
				if (tally_q >= TW'(MAX_BLOCK)) begin
					ovf_q <= 1'b1;
				end else begin
					sum_q   <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
					tally_q <= tally_q + 1'b1;
				end
			end
			if (cmd.div_start) begin
				peak_q  <= '0;
				sum_q   <= '0;
				tally_q <= '0;
				ovf_q   <= 1'b0;
			end
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			mag_s1  <= mag;
			last_s1 <= last;
		end
		if (cmd.do_mul) sq_s2 <= SQ_W'(mag_s1 * mag_s1);
		if (cmd.div_start) begin
			pk_hold_q <= peak_q;
			res_ovf_q <= ovf_q;
			tzero_q   <= (tally_q == '0);
			dvd_q     <= sum_q;
			dvs_q     <= tally_q;
			rem_q     <= '0;
			div_cnt_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q     <= qbit ? TW'(rem2 - {1'b0, dvs_q}) : rem2[TW-1:0];
			dvd_q     <= {dvd_q[SUM_W-2:0], qbit};
			div_cnt_q <= div_cnt_q + 1'b1;
		end
		if (cmd.log_load) begin
			lx_q    <= cmd.log_sel ? dvd_q : 64'(pk_hold_q);
			lp_q    <= 6'd63;
			lzero_q <= cmd.log_sel ? (tzero_q || dvd_q == '0) : (pk_hold_q == '0);
		end
		if (cmd.log_norm && !lx_q[63] && lp_q != 6'd0) begin
			lx_q <= {lx_q[62:0], 1'b0};
			lp_q <= lp_q - 1'b1;
		end
		if (cmd.log_sub) begin
			ge_q   <= (l22 >= ref22);
			diff_q <= ref22 - l22;
		end
		if (cmd.log_prod) lprod_q <= diff_q * (cmd.log_sel ? K10_Q16 : K20_Q16);
		if (cmd.log_fin) begin
			if (cmd.log_sel) rres_q <= lvl;
			else pres_q <= lvl;
		end
		if (cmd.out_load) begin
			peak_db        <= pres_q[11:0];
			rms_db         <= rres_q[11:0];
			block_too_long <= res_ovf_q;
			if (crest[LVL_W]) crest_db <= '0;
			else if (crest > (LVL_W + 1)'(2047)) crest_db <= 11'h7FF;
			else crest_db <= crest[10:0];
		end
	end

endmodule
